// File: sv/tdms_pkg.sv
// Shared constants, types and codes for the tank drive mixer with slew limiter.
package tdms_pkg;

  localparam int FRAC_BITS = 14;
  localparam int SPD_W     = 16;
  localparam int MIX_W     = SPD_W + 1;
  localparam int REM_W     = MIX_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int RATE_W    = 15;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 32;

  localparam logic [MIX_W-1:0]  ONE        = MIX_W'(1) << FRAC_BITS;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1638);

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic load_in;
    logic load_mag;
    logic store_direct;
    logic div_start;
    logic div_side;
    logic div_step;
    logic store_left_q;
    logic store_final;
    logic tick_update;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: sv/tdms_ctrl.sv
// Sequencer for set and tick requests: mixing, two-pass normalisation, tick update.
module tdms_ctrl
  import tdms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAG  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIVL = 3'd3;
  localparam logic [2:0] S_DIVR = 3'd4;
  localparam logic [2:0] S_TICK = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = (s_tuser == CMD_TICK) ? S_TICK : S_MAG;
        end
      end
      S_MAG: begin
        cmd.load_mag = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          cmd.div_side  = 1'b0;
          state_next    = S_DIVL;
        end else begin
          cmd.store_direct = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_DIVL: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.store_left_q = 1'b1;
          cmd.div_start    = 1'b1;
          cmd.div_side     = 1'b1;
          state_next       = S_DIVR;
        end
      end
      S_DIVR: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.store_final = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.tick_update = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/tdms_dp.sv
// Datapath: mixer, shared restoring divider, speed state, slew step and output register.
module tdms_dp
  import tdms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  function automatic logic signed [SPD_W-1:0] slew_step(
    input logic signed [SPD_W-1:0] cur,
    input logic signed [SPD_W-1:0] tgt,
    input logic [RATE_W-1:0]       rate
  );
    logic signed [MIX_W-1:0] inc;
    logic [MIX_W-1:0]        inc_mag;
    logic signed [MIX_W-1:0] cur_x;
    logic signed [MIX_W-1:0] rate_x;
    logic signed [MIX_W-1:0] moved;
    cur_x   = MIX_W'(cur);
    rate_x  = $signed({2'b00, rate});
    inc     = MIX_W'(tgt) - cur_x;
    inc_mag = inc[MIX_W-1] ? MIX_W'(-inc) : MIX_W'(inc);
    if (inc_mag > {2'b00, rate}) begin
      moved = inc[MIX_W-1] ? (cur_x - rate_x) : (cur_x + rate_x);
      return moved[SPD_W-1:0];
    end
    return tgt;
  endfunction

  logic [RATE_W-1:0]       slew_rate;
  logic signed [MIX_W-1:0] mix_l;
  logic signed [MIX_W-1:0] mix_r;
  logic                    skip;
  logic [MIX_W-1:0]        abs_l;
  logic [MIX_W-1:0]        abs_r;
  logic [MIX_W-1:0]        mag_max;
  logic [REM_W-1:0]        rem;
  logic [QUO_W-1:0]        quo;
  logic [CNT_W-1:0]        cnt;
  logic                    div_sel;
  logic signed [SPD_W-1:0] quo_left;
  logic signed [SPD_W-1:0] target_left;
  logic signed [SPD_W-1:0] target_right;
  logic signed [SPD_W-1:0] current_left;
  logic signed [SPD_W-1:0] current_right;
  logic signed [SPD_W-1:0] left_drive;
  logic signed [SPD_W-1:0] right_drive;

  logic signed [SPD_W-1:0] fwd_in;
  logic signed [SPD_W-1:0] yaw_in;
  logic [MIX_W-1:0]        abs_l_next;
  logic [MIX_W-1:0]        abs_r_next;
  logic [REM_W-1:0]        div_ref;
  logic                    div_ge;
  logic [REM_W-1:0]        rem_keep;
  logic [QUO_W-1:0]        quo_fin;
  logic [SPD_W-1:0]        quo_ext;
  logic signed [SPD_W-1:0] div_res;
  logic                    div_neg;
  logic signed [SPD_W-1:0] step_left;
  logic signed [SPD_W-1:0] step_right;

  assign fwd_in     = s_tdata[15:0];
  assign yaw_in     = s_tdata[31:16];
  assign abs_l_next = mix_l[MIX_W-1] ? MIX_W'(-mix_l) : MIX_W'(mix_l);
  assign abs_r_next = mix_r[MIX_W-1] ? MIX_W'(-mix_r) : MIX_W'(mix_r);

  assign div_ref  = {1'b0, mag_max};
  assign div_ge   = (rem >= div_ref);
  assign rem_keep = div_ge ? (rem - div_ref) : rem;
  assign quo_fin  = {quo[QUO_W-2:0], div_ge};
  assign quo_ext  = SPD_W'(quo_fin);
  assign div_neg  = div_sel ? mix_r[MIX_W-1] : mix_l[MIX_W-1];
  assign div_res  = div_neg ? $signed(-quo_ext) : $signed(quo_ext);

  assign step_left  = slew_step(current_left, target_left, slew_rate);
  assign step_right = slew_step(current_right, target_right, slew_rate);

  assign sts.need_div = (mag_max > ONE);
  assign sts.div_last = (cnt == CNT_W'(QUO_W - 1));
  assign sts.out_free = !m_tvalid || m_tready;

  assign m_tdata = {right_drive, left_drive};

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_rate     <= RATE_RESET;
      target_left   <= '0;
      target_right  <= '0;
      current_left  <= '0;
      current_right <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        slew_rate <= cfg_wdata;
      end
      if (cmd.store_direct) begin
        target_left  <= mix_l[SPD_W-1:0];
        target_right <= mix_r[SPD_W-1:0];
        if (skip) begin
          current_left  <= mix_l[SPD_W-1:0];
          current_right <= mix_r[SPD_W-1:0];
        end
      end
      if (cmd.store_final) begin
        target_left  <= quo_left;
        target_right <= div_res;
        if (skip) begin
          current_left  <= quo_left;
          current_right <= div_res;
        end
      end
      if (cmd.tick_update) begin
        current_left  <= step_left;
        current_right <= step_right;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mix_l <= MIX_W'(fwd_in) + MIX_W'(yaw_in);
      mix_r <= MIX_W'(fwd_in) - MIX_W'(yaw_in);
      skip  <= s_tdata[32];
    end
    if (cmd.load_mag) begin
      abs_l   <= abs_l_next;
      abs_r   <= abs_r_next;
      mag_max <= (abs_l_next > abs_r_next) ? abs_l_next : abs_r_next;
    end
    if (cmd.store_left_q) begin
      quo_left <= div_res;
    end
    if (cmd.div_start) begin
      rem     <= {1'b0, (cmd.div_side ? abs_r : abs_l)};
      quo     <= '0;
      cnt     <= '0;
      div_sel <= cmd.div_side;
    end else if (cmd.div_step) begin
      rem <= {rem_keep[REM_W-2:0], 1'b0};
      quo <= quo_fin;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.tick_update) begin
      left_drive  <= step_left;
      right_drive <= step_right;
    end
  end

endmodule

// File: sv/tank_drive_mix_slew_limiter.sv
// Top level of the tank drive mixer with slew-rate limiter.
// Set requests (tuser 0) mix forward and yaw into left/right targets and, when the
// larger magnitude exceeds full speed (16384), scale both by a shared restoring
// divider that resolves one quotient bit per cycle for each side in turn. Tick
// requests (tuser 1) wait for the output register to drain, then return one result
// with both slew-limited speeds. A new request is taken while a finished result
// still waits on the master side. slew_rate resets to 1638.
module tank_drive_mix_slew_limiter
  import tdms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // forward_speed[15:0], yaw_rate[31:16], skip_slew[32]
  input  logic              s_tuser,   // cmd[0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // left_drive[15:0], right_drive[31:16]
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tdms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdms_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: sv/tdms_checker.sv
// Port-level checks for the tank drive mixer, bound to the top level.
module tdms_checker
  import tdms_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_SET) |=> !$rose(m_tvalid))
    else $error("result raised by a set request");

endmodule

bind tank_drive_mix_slew_limiter tdms_checker u_tdms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
